// ----- sv/wgpc_pkg.sv -----
`default_nettype none
package wgpc_pkg;

  localparam int CompW   = 8;
  localparam int WeightW = 24;
  localparam int GrayW   = 24;
  localparam int WordW   = 32;
  localparam int ProdW   = 32;
  localparam int AccW    = 34;
  localparam int RecipW  = 28;
  localparam int IdxW    = 8;
  localparam int FmtW    = 3;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [FmtW-1:0] FMT_BGRX   = 3'd0;
  localparam logic [FmtW-1:0] FMT_BGR    = 3'd1;
  localparam logic [FmtW-1:0] FMT_RGB555 = 3'd2;
  localparam logic [FmtW-1:0] FMT_PAL8   = 3'd3;
  localparam logic [FmtW-1:0] FMT_PAL4   = 3'd4;

  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_CONVERT   = 1'b1;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_WEIGHT_R = 2'd1;
  localparam logic [1:0] REG_WEIGHT_G = 2'd2;
  localparam logic [1:0] REG_WEIGHT_B = 2'd3;

  localparam logic [CompW-1:0] DIV_8BIT = 8'd255;
  localparam logic [CompW-1:0] DIV_5BIT = 8'd31;

  // floor(2^32 / D): quotient estimate is at most one below the true value
  localparam logic [RecipW-1:0] RECIP_8BIT = RecipW'((64'd1 << 32) / 64'd255);
  localparam logic [RecipW-1:0] RECIP_5BIT = RecipW'((64'd1 << 32) / 64'd31);

  // sums at or above D * 2^24 saturate
  localparam logic [AccW-1:0] SAT_8BIT = AccW'(64'd255 << 24);
  localparam logic [AccW-1:0] SAT_5BIT = AccW'(64'd31 << 24);

  typedef logic [CompW-1:0] comp_t;
  typedef logic [GrayW-1:0] gray_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
  } rgb_t;

endpackage
`default_nettype wire

// ----- sv/wgpc_in_if.sv -----
`default_nettype none
interface wgpc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [wgpc_pkg::IdxW-1:0]         palette_index;
  wgpc_pkg::comp_t                   palette_red;
  wgpc_pkg::comp_t                   palette_green;
  wgpc_pkg::comp_t                   palette_blue;
  logic [wgpc_pkg::WordW-1:0]        pixel_word;

  modport source (
    output valid, func, palette_index, palette_red, palette_green, palette_blue,
           pixel_word,
    input  ready
  );

  modport sink (
    input  valid, func, palette_index, palette_red, palette_green, palette_blue,
           pixel_word,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/wgpc_out_if.sv -----
`default_nettype none
interface wgpc_out_if;
  logic            valid;
  logic            ready;
  wgpc_pkg::gray_t gray_level;
  logic            last_of_item;

  modport source (
    output valid, gray_level, last_of_item,
    input  ready
  );

  modport sink (
    input  valid, gray_level, last_of_item,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/wgpc_ram.sv -----
`default_nettype none
module wgpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

// ----- sv/weighted_gray_pixel_convert.sv -----
`default_nettype none
// Weighted gray converter. Takes one input transaction per clock while not
// stalled and returns gray levels (unsigned Q8.16, saturated) in input order.
// Formats 0..3 give one result per pixel word, so one word per clock is
// sustained while the output is ready; the 4-bit palette format gives two
// results per word and the single result register then holds back the next
// word until both are taken. Palette writes (func 0) and convert transactions
// under an undefined pixel_format give no result. The palette lives in a
// two-read-port RAM of PALETTE_ENTRIES x 24 bits with no reset: an entry must
// be written before a pixel refers to it. Registers (pixel_format, weights)
// may only be written while no transaction is in flight.
module weighted_gray_pixel_convert #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  wgpc_in_if.sink                             in_if,
  wgpc_out_if.source                          out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wgpc_pkg::AddrW-1:0]     paddr,
  input  wire logic [wgpc_pkg::DataW-1:0]     pwdata,
  output logic      [wgpc_pkg::DataW-1:0]     prdata,
  output logic                                pready
);

  localparam int PalAw = $clog2(PALETTE_ENTRIES);
  localparam logic [wgpc_pkg::IdxW:0] PalLimit = (wgpc_pkg::IdxW + 1)'(PALETTE_ENTRIES);
  localparam int MulW = wgpc_pkg::WordW + wgpc_pkg::RecipW;

  typedef struct packed {
    logic two;
    logic div31;
  } ctl_t;

  // configuration
  logic [wgpc_pkg::FmtW-1:0]    pixel_format_r;
  logic [wgpc_pkg::WeightW-1:0] weight_red_r;
  logic [wgpc_pkg::WeightW-1:0] weight_green_r;
  logic [wgpc_pkg::WeightW-1:0] weight_blue_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= '0;
      weight_red_r   <= '0;
      weight_green_r <= '0;
      weight_blue_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wgpc_pkg::REG_FORMAT:   pixel_format_r <= pwdata[wgpc_pkg::FmtW-1:0];
        wgpc_pkg::REG_WEIGHT_R: weight_red_r   <= pwdata[wgpc_pkg::WeightW-1:0];
        wgpc_pkg::REG_WEIGHT_G: weight_green_r <= pwdata[wgpc_pkg::WeightW-1:0];
        wgpc_pkg::REG_WEIGHT_B: weight_blue_r  <= pwdata[wgpc_pkg::WeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wgpc_pkg::REG_FORMAT:   prdata = wgpc_pkg::DataW'(pixel_format_r);
      wgpc_pkg::REG_WEIGHT_R: prdata = wgpc_pkg::DataW'(weight_red_r);
      wgpc_pkg::REG_WEIGHT_G: prdata = wgpc_pkg::DataW'(weight_green_r);
      wgpc_pkg::REG_WEIGHT_B: prdata = wgpc_pkg::DataW'(weight_blue_r);
      default:                prdata = '0;
    endcase
  end

  // pipeline flow control
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic free_a, free_b, free_c, free_d, free_e;
  logic sel_e_r;
  ctl_t ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r, ctl_e_r;
  logic out_last;
  logic in_acc;

  assign out_last = !ctl_e_r.two || sel_e_r;
  assign free_e   = !v_e_r || (out_if.ready && out_last);
  assign free_d   = !v_d_r || free_e;
  assign free_c   = !v_c_r || free_d;
  assign free_b   = !v_b_r || free_c;
  assign free_a   = !v_a_r || free_b;
  assign in_if.ready = free_a;
  assign in_acc   = in_if.valid && free_a;

  // input decode
  logic [wgpc_pkg::WordW-1:0] w;
  logic [wgpc_pkg::IdxW-1:0]  idx0, idx1;
  logic                       fmt_ok, is_pal, is_pal4;
  wgpc_pkg::rgb_t             pix_nxt;
  ctl_t                       ctl_a_nxt;
  logic                       pal_we;

  assign w = in_if.pixel_word;

  always_comb begin
    fmt_ok  = 1'b1;
    is_pal  = 1'b0;
    is_pal4 = 1'b0;
    pix_nxt = '0;
    case (pixel_format_r)
      wgpc_pkg::FMT_BGRX, wgpc_pkg::FMT_BGR: begin
        pix_nxt = '{r: w[23:16], g: w[15:8], b: w[7:0]};
      end
      wgpc_pkg::FMT_RGB555: begin
        pix_nxt = '{r: {3'b000, w[14:10]}, g: {3'b000, w[9:5]}, b: {3'b000, w[4:0]}};
      end
      wgpc_pkg::FMT_PAL8: begin
        is_pal = 1'b1;
      end
      wgpc_pkg::FMT_PAL4: begin
        is_pal  = 1'b1;
        is_pal4 = 1'b1;
      end
      default: begin
        fmt_ok = 1'b0;
      end
    endcase
    idx0 = is_pal4 ? {4'b0000, w[7:4]} : w[7:0];
    idx1 = {4'b0000, w[3:0]};
    ctl_a_nxt.two   = is_pal4;
    ctl_a_nxt.div31 = (pixel_format_r == wgpc_pkg::FMT_RGB555);
  end

  assign pal_we = in_acc && (in_if.func == wgpc_pkg::FUNC_PAL_WRITE) &&
                  ({1'b0, in_if.palette_index} < PalLimit);

  logic [23:0] rd_data0, rd_data1;

  wgpc_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .we     (pal_we),
    .waddr  (in_if.palette_index[PalAw-1:0]),
    .wdata  ({in_if.palette_red, in_if.palette_green, in_if.palette_blue}),
    .re     (free_a),
    .raddr0 (idx0[PalAw-1:0]),
    .raddr1 (idx1[PalAw-1:0]),
    .rdata0 (rd_data0),
    .rdata1 (rd_data1)
  );

  // stage A: input register, palette read data
  wgpc_pkg::rgb_t pix_a_r;
  logic           pal_a_r;
  logic [1:0]     ok_a_r;

  always_ff @(posedge clk) begin
    if (free_a) begin
      pix_a_r <= pix_nxt;
      pal_a_r <= is_pal;
      ok_a_r  <= {({1'b0, idx1} < PalLimit), ({1'b0, idx0} < PalLimit)};
      ctl_a_r <= ctl_a_nxt;
    end
  end

  wgpc_pkg::rgb_t lane_a [2];

  always_comb begin
    lane_a[0] = pal_a_r ? (ok_a_r[0] ? wgpc_pkg::rgb_t'(rd_data0) : '0) : pix_a_r;
    lane_a[1] = ok_a_r[1] ? wgpc_pkg::rgb_t'(rd_data1) : '0;
  end

  // stage B: products
  logic [wgpc_pkg::ProdW-1:0] prod_b_r [2][3];

  always_ff @(posedge clk) begin
    if (free_b) begin
      for (int l = 0; l < 2; l++) begin
        prod_b_r[l][0] <= wgpc_pkg::ProdW'(lane_a[l].r) * wgpc_pkg::ProdW'(weight_red_r);
        prod_b_r[l][1] <= wgpc_pkg::ProdW'(lane_a[l].g) * wgpc_pkg::ProdW'(weight_green_r);
        prod_b_r[l][2] <= wgpc_pkg::ProdW'(lane_a[l].b) * wgpc_pkg::ProdW'(weight_blue_r);
      end
      ctl_b_r <= ctl_a_r;
    end
  end

  // stage C: sum and saturation check
  logic [wgpc_pkg::AccW-1:0]  acc_nxt [2];
  logic [wgpc_pkg::AccW-1:0]  sat_lim;
  logic [wgpc_pkg::WordW-1:0] x_c_r [2];
  logic [1:0]                 sat_c_r;

  assign sat_lim = ctl_b_r.div31 ? wgpc_pkg::SAT_5BIT : wgpc_pkg::SAT_8BIT;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc_nxt[l] = wgpc_pkg::AccW'(prod_b_r[l][0]) + wgpc_pkg::AccW'(prod_b_r[l][1]) +
                   wgpc_pkg::AccW'(prod_b_r[l][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (free_c) begin
      for (int l = 0; l < 2; l++) begin
        x_c_r[l]   <= acc_nxt[l][wgpc_pkg::WordW-1:0];
        sat_c_r[l] <= (acc_nxt[l] >= sat_lim);
      end
      ctl_c_r <= ctl_b_r;
    end
  end

  // stage D: reciprocal multiply, quotient estimate
  logic [wgpc_pkg::RecipW-1:0] recip;
  logic [MulW-1:0]             mul_nxt [2];
  logic [wgpc_pkg::WordW-1:0]  x_d_r [2];
  wgpc_pkg::gray_t             q0_d_r [2];
  logic [1:0]                  sat_d_r;

  assign recip = ctl_c_r.div31 ? wgpc_pkg::RECIP_5BIT : wgpc_pkg::RECIP_8BIT;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mul_nxt[l] = MulW'(x_c_r[l]) * MulW'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (free_d) begin
      for (int l = 0; l < 2; l++) begin
        q0_d_r[l] <= mul_nxt[l][wgpc_pkg::WordW +: wgpc_pkg::GrayW];
        x_d_r[l]  <= x_c_r[l];
      end
      sat_d_r <= sat_c_r;
      ctl_d_r <= ctl_c_r;
    end
  end

  // stage E: remainder correction into the result register
  logic [wgpc_pkg::WordW-1:0] qd [2];
  logic [wgpc_pkg::WordW-1:0] rem [2];
  wgpc_pkg::gray_t            gray_nxt [2];
  wgpc_pkg::gray_t            gray_e_r [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qd[l] = ctl_d_r.div31 ?
              (wgpc_pkg::WordW'(q0_d_r[l]) << 5) - wgpc_pkg::WordW'(q0_d_r[l]) :
              (wgpc_pkg::WordW'(q0_d_r[l]) << 8) - wgpc_pkg::WordW'(q0_d_r[l]);
      rem[l] = x_d_r[l] - qd[l];
      if (sat_d_r[l]) begin
        gray_nxt[l] = '1;
      end else if (rem[l] >= wgpc_pkg::WordW'(ctl_d_r.div31 ? wgpc_pkg::DIV_5BIT :
                                                              wgpc_pkg::DIV_8BIT)) begin
        gray_nxt[l] = q0_d_r[l] + 1'b1;
      end else begin
        gray_nxt[l] = q0_d_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_e) begin
      gray_e_r <= gray_nxt;
      ctl_e_r  <= ctl_d_r;
    end
  end

  // valid bits and result lane select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r   <= 1'b0;
      v_b_r   <= 1'b0;
      v_c_r   <= 1'b0;
      v_d_r   <= 1'b0;
      v_e_r   <= 1'b0;
      sel_e_r <= 1'b0;
    end else begin
      if (free_a) begin
        v_a_r <= in_acc && (in_if.func == wgpc_pkg::FUNC_CONVERT) && fmt_ok;
      end
      if (free_b) begin
        v_b_r <= v_a_r;
      end
      if (free_c) begin
        v_c_r <= v_b_r;
      end
      if (free_d) begin
        v_d_r <= v_c_r;
      end
      if (free_e) begin
        v_e_r   <= v_d_r;
        sel_e_r <= 1'b0;
      end else if (out_if.ready) begin
        sel_e_r <= 1'b1;
      end
    end
  end

  assign out_if.valid        = v_e_r;
  assign out_if.gray_level   = sel_e_r ? gray_e_r[1] : gray_e_r[0];
  assign out_if.last_of_item = out_last;

endmodule
`default_nettype wire

// ----- sv/wgpc_chk.sv -----
`default_nettype none
module wgpc_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_last,
  input wire logic [wgpc_pkg::GrayW-1:0] out_gray
);

  // held result must not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gray) && $stable(out_last))
    else $error("result changed while stalled");

  // first half of a two-result transaction is followed at once by its last half
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second result of a pair missing");

  // with nothing waiting at the output the pipeline cannot be stalled
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result presented right after reset");

endmodule

bind weighted_gray_pixel_convert wgpc_chk u_wgpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.last_of_item),
  .out_gray  (out_if.gray_level)
);
`default_nettype wire
